/* hdl/msse_pkg.sv */
// Shared constants and functions for the monkey saddle surface evaluator.
`default_nettype none
package msse_pkg;

   localparam int unsigned SINE_TABLE_ADDR_BITS = 10;
   localparam logic signed [15:0] GAIN_RESET = 16'sd4096;
   localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

   // Build one quarter-wave sine entry, Q16, from a Q30 Taylor series.
   function automatic logic [16:0] sine_entry(input int unsigned k, input int unsigned ab);
      longint unsigned q;
      longint unsigned th;
      longint unsigned th2;
      longint unsigned term;
      longint sum;
      longint val;
      q = 64'd1 << ab;
      th = (PI_HALF_Q30 * longint'(k) + (q >> 1)) >> ab;
      th2 = (th * th + (64'd1 << 29)) >> 30;
      term = th;
      sum = longint'(th);
      term = ((term * th2) >> 30) / 64'd6;
      sum = sum - longint'(term);
      term = ((term * th2) >> 30) / 64'd20;
      sum = sum + longint'(term);
      term = ((term * th2) >> 30) / 64'd42;
      sum = sum - longint'(term);
      term = ((term * th2) >> 30) / 64'd72;
      sum = sum + longint'(term);
      term = ((term * th2) >> 30) / 64'd110;
      sum = sum - longint'(term);
      term = ((term * th2) >> 30) / 64'd156;
      sum = sum + longint'(term);
      if (sum < 0) begin
         sum = 0;
      end
      val = (sum + 8192) >>> 14;
      if (val > 65536) begin
         val = 65536;
      end
      return val[16:0];
   endfunction

   // Round half up, drop 28 fraction bits.
   function automatic logic signed [28:0] rnd28(input logic signed [55:0] x);
      logic signed [56:0] t;
      t = {x[55], x} + 57'sd134217728;
      return t[56:28];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [39:0] x);
      logic [31:0] r;
      if (x > 40'sd2147483647) begin
         r = 32'h7FFF_FFFF;
      end else if (x < -40'sd2147483648) begin
         r = 32'h8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

/* hdl/msse_sin_lut.sv */
// Quarter-wave sine table lookup, signed Q16 result over a full turn.
`default_nettype none
module msse_sin_lut
   import msse_pkg::*;
#(
   parameter int unsigned ADDR_BITS = SINE_TABLE_ADDR_BITS
) (
   input  logic [15:0]        angle,
   output logic signed [17:0] sine
);
   localparam int unsigned Q = 1 << ADDR_BITS;

   logic [16:0] tab [Q+1];
   logic [ADDR_BITS-1:0] off;
   logic [ADDR_BITS:0] idx;
   logic [16:0] mag;

   for (genvar k = 0; k <= Q; k++) begin : g_tab
      assign tab[k] = sine_entry(k, ADDR_BITS);
   end

   assign off = angle[13 -: ADDR_BITS];
   assign idx = angle[14] ? ((ADDR_BITS+1)'(Q) - {1'b0, off}) : {1'b0, off};
   assign mag = tab[idx];
   assign sine = angle[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule
`default_nettype wire

/* hdl/monkey_saddle_surface_eval_unit.sv */
// Top level: pipelined monkey saddle point, tangent and normal evaluator.
//
//  port group | dir | transfer contents
//  req_*      | in  | tdata[15:0] radius, tdata[31:16] angle
//  rsp_*      | out | tdata 12 x 32: point xyz, du xyz, dv xyz, normal xyz
//  csr_*      | in  | height_gain write, no read-back
//
//  Six register stages; one item per cycle while the output is not stalled.
//  The pipeline advances as a whole when the last stage is empty or taken.
//  A stall holds every stage; nothing is dropped or repeated.
//  Reset clears stage valid bits and sets height_gain to 1.0.
`default_nettype none
module monkey_saddle_surface_eval_unit
   import msse_pkg::*;
#(
   parameter int unsigned ADDR_BITS = SINE_TABLE_ADDR_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // radius, angle
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [383:0] rsp_tdata,   // point_x..z, du_x..z, dv_x..z, normal_x..z
   input  logic         csr_wen,
   input  logic [15:0]  csr_wdata
);
   logic en;
   logic signed [15:0] gain_ff;
   logic [6:1] vld_ff;

   // stage 1
   logic signed [15:0] u_in, u1_ff, a1_ff;
   logic [15:0] ang, ang2, ang3;
   logic signed [17:0] sv_in, cv_in, s3_in, c3_in, s2_in, c2_in;
   logic signed [17:0] sv1_ff, cv1_ff, s31_ff, c31_ff, s21_ff, c21_ff;
   logic signed [31:0] uu1_ff;
   logic pos1_ff, neg1_ff;
   // stage 2
   logic signed [33:0] pxt, pyt;
   logic signed [31:0] u2t;
   logic signed [19:0] px2_ff, py2_ff, u22_ff;
   logic signed [47:0] uuu2_ff;
   logic signed [15:0] a2_ff;
   logic signed [17:0] sv2_ff, cv2_ff, s32_ff, c32_ff, s22_ff, c22_ff;
   logic pos2_ff, neg2_ff;
   // stage 3
   logic signed [47:0] u3t;
   logic signed [21:0] u33_ff;
   logic signed [35:0] au23_ff;
   logic signed [15:0] a3_ff;
   logic signed [19:0] px3_ff, py3_ff;
   logic signed [17:0] sv3_ff, cv3_ff, s33_ff, c33_ff, s23_ff, c23_ff;
   logic pos3_ff, neg3_ff;
   // stage 4
   logic signed [37:0] g_in, gs_in, au34_ff, g4_ff, gs4_ff;
   logic signed [19:0] px4_ff, py4_ff;
   logic signed [17:0] sv4_ff, cv4_ff, s34_ff, c34_ff, s24_ff, c24_ff;
   logic pos4_ff, neg4_ff;
   // stage 5
   logic signed [55:0] z5_ff, dz5_ff, vz5_ff, nx5_ff, ny5_ff;
   logic signed [19:0] px5_ff, py5_ff;
   logic signed [17:0] sv5_ff, cv5_ff;
   logic pos5_ff, neg5_ff;
   // stage 6
   logic [383:0] out_in, out_ff;
   logic signed [17:0] dvx, dvy, nz;

   assign en = !vld_ff[6] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[6];
   assign rsp_tdata = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_wen) begin
         gain_ff <= $signed(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:1], req_tvalid};
      end
   end

   assign u_in = $signed(req_tdata[15:0]);
   assign ang  = req_tdata[31:16];
   assign ang2 = {ang[14:0], 1'b0};
   assign ang3 = ang + ang2;

   msse_sin_lut #(.ADDR_BITS(ADDR_BITS)) u_sv (.angle(ang), .sine(sv_in));
   msse_sin_lut #(.ADDR_BITS(ADDR_BITS)) u_cv (.angle(ang + 16'h4000), .sine(cv_in));
   msse_sin_lut #(.ADDR_BITS(ADDR_BITS)) u_s3 (.angle(ang3), .sine(s3_in));
   msse_sin_lut #(.ADDR_BITS(ADDR_BITS)) u_c3 (.angle(ang3 + 16'h4000), .sine(c3_in));
   msse_sin_lut #(.ADDR_BITS(ADDR_BITS)) u_s2 (.angle(ang2), .sine(s2_in));
   msse_sin_lut #(.ADDR_BITS(ADDR_BITS)) u_c2 (.angle(ang2 + 16'h4000), .sine(c2_in));

   assign pxt = u1_ff * cv1_ff + 34'sd8192;
   assign pyt = u1_ff * sv1_ff + 34'sd8192;
   assign u2t = uu1_ff + 32'sd2048;
   assign u3t = uuu2_ff + 48'sd33554432;
   assign g_in = 38'(au23_ff) + (38'(au23_ff) <<< 1);
   assign gs_in = pos3_ff ? g_in : (neg3_ff ? -g_in : '0);

   always_ff @(posedge clock) begin
      if (en) begin
         u1_ff <= u_in;
         a1_ff <= gain_ff;
         uu1_ff <= u_in * u_in;
         pos1_ff <= !u_in[15] && (u_in != 16'sd0);
         neg1_ff <= u_in[15];
         sv1_ff <= sv_in; cv1_ff <= cv_in; s31_ff <= s3_in;
         c31_ff <= c3_in; s21_ff <= s2_in; c21_ff <= c2_in;

         px2_ff <= pxt[33:14];
         py2_ff <= pyt[33:14];
         u22_ff <= u2t[31:12];
         uuu2_ff <= uu1_ff * u1_ff;
         a2_ff <= a1_ff;
         pos2_ff <= pos1_ff; neg2_ff <= neg1_ff;
         sv2_ff <= sv1_ff; cv2_ff <= cv1_ff; s32_ff <= s31_ff;
         c32_ff <= c31_ff; s22_ff <= s21_ff; c22_ff <= c21_ff;

         u33_ff <= u3t[47:26];
         au23_ff <= a2_ff * u22_ff;
         a3_ff <= a2_ff;
         px3_ff <= px2_ff; py3_ff <= py2_ff;
         pos3_ff <= pos2_ff; neg3_ff <= neg2_ff;
         sv3_ff <= sv2_ff; cv3_ff <= cv2_ff; s33_ff <= s32_ff;
         c33_ff <= c32_ff; s23_ff <= s22_ff; c23_ff <= c22_ff;

         au34_ff <= a3_ff * u33_ff;
         g4_ff <= g_in;
         gs4_ff <= gs_in;
         px4_ff <= px3_ff; py4_ff <= py3_ff;
         pos4_ff <= pos3_ff; neg4_ff <= neg3_ff;
         sv4_ff <= sv3_ff; cv4_ff <= cv3_ff; s34_ff <= s33_ff;
         c34_ff <= c33_ff; s24_ff <= s23_ff; c24_ff <= c23_ff;

         z5_ff <= au34_ff * s34_ff;
         dz5_ff <= g4_ff * s34_ff;
         vz5_ff <= gs4_ff * c34_ff;
         nx5_ff <= gs4_ff * s24_ff;
         ny5_ff <= gs4_ff * c24_ff;
         px5_ff <= px4_ff; py5_ff <= py4_ff;
         pos5_ff <= pos4_ff; neg5_ff <= neg4_ff;
         sv5_ff <= sv4_ff; cv5_ff <= cv4_ff;

         out_ff <= out_in;
      end
   end

   assign dvx = pos5_ff ? -sv5_ff : (neg5_ff ? sv5_ff : '0);
   assign dvy = pos5_ff ? cv5_ff : (neg5_ff ? -cv5_ff : '0);
   assign nz  = pos5_ff ? 18'sd65536 : (neg5_ff ? -18'sd65536 : '0);

   always_comb begin
      out_in[31:0]    = sat32(40'(px5_ff));
      out_in[63:32]   = sat32(40'(py5_ff));
      out_in[95:64]   = sat32(40'(rnd28(z5_ff)));
      out_in[127:96]  = sat32(40'(cv5_ff));
      out_in[159:128] = sat32(40'(sv5_ff));
      out_in[191:160] = sat32(40'(rnd28(dz5_ff)));
      out_in[223:192] = sat32(40'(dvx));
      out_in[255:224] = sat32(40'(dvy));
      out_in[287:256] = sat32(40'(rnd28(vz5_ff)));
      out_in[319:288] = sat32(-40'(rnd28(nx5_ff)));
      out_in[351:320] = sat32(-40'(rnd28(ny5_ff)));
      out_in[383:352] = sat32(40'(nz));
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");
   a_nz_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[383:352] == 32'h0001_0000 ||
                      rsp_tdata[383:352] == 32'hFFFF_0000 ||
                      rsp_tdata[383:352] == 32'h0000_0000))
      else $error("normal_z not a sign");
   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[383:352] == 32'h0) |->
      (rsp_tdata[223:192] == 32'h0 && rsp_tdata[255:224] == 32'h0 &&
       rsp_tdata[319:288] == 32'h0 && rsp_tdata[351:320] == 32'h0))
      else $error("zero radius with nonzero dv or normal");
   a_pos_radius: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[383:352] == 32'h0001_0000) |->
      (rsp_tdata[255:224] == rsp_tdata[127:96]))
      else $error("dv_y differs from du_x for positive radius");

endmodule
`default_nettype wire

/* bench/monkey_saddle_surface_eval_unit_test.sv */
// Self-checking bench for the monkey saddle surface evaluator: directed table, random samples.
`default_nettype none
module monkey_saddle_surface_eval_unit_test
   import msse_pkg::*;
();

   localparam int unsigned TAB_Q = 1 << SINE_TABLE_ADDR_BITS;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 1000;
   localparam int PIPE_DEPTH = 6;

   typedef enum int {MODE_FREE, MODE_SRC_GAPS, MODE_SINK_STALLS, MODE_BOTH} pace_type;

   typedef struct packed {
      logic signed [15:0] radius;
      logic [15:0]        angle;
   } sample_type;

   typedef logic [383:0] surface_type;

   typedef struct {
      sample_type  smp;
      logic        has_fixed;
      surface_type fixed;
   } table_row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [31:0]  req_tdata;   // radius, angle
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [383:0] rsp_tdata;   // point_x..z, du_x..z, dv_x..z, normal_x..z
   logic         csr_wen;
   logic [15:0]  csr_wdata;

   monkey_saddle_surface_eval_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   longint             quarter_sine [0:TAB_Q];
   logic signed [15:0] gain_model;
   surface_type        expected_surfaces [$];
   logic               failed;
   pace_type           pace;
   int                 idle_cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint shift_round(longint x, int s);
      longint t;
      t = x + (longint'(1) << (s - 1));
      return t >>> s;
   endfunction

   function automatic longint table_sine(logic [15:0] ang);
      logic [1:0] quad;
      int unsigned off;
      int unsigned idx;
      quad = ang[15:14];
      off = int'(ang[13:0]) >> (14 - SINE_TABLE_ADDR_BITS);
      idx = quad[0] ? TAB_Q - off : off;
      return quad[1] ? -quarter_sine[idx] : quarter_sine[idx];
   endfunction

   function automatic logic [31:0] clamp32(longint x);
      if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[31:0];
   endfunction

   function automatic surface_type eval_surface(sample_type smp, logic signed [15:0] gain);
      longint u, a, sg, sv, cv, s3, c3, s2, c2, u2, u3, g;
      logic [15:0] ang2, ang3;
      surface_type r;
      u = smp.radius;
      a = gain;
      sg = (u > 0) ? 1 : ((u < 0) ? -1 : 0);
      ang2 = smp.angle * 2;
      ang3 = smp.angle * 3;
      sv = table_sine(smp.angle);
      cv = table_sine(smp.angle + 16'd16384);
      s3 = table_sine(ang3);
      c3 = table_sine(ang3 + 16'd16384);
      s2 = table_sine(ang2);
      c2 = table_sine(ang2 + 16'd16384);
      u2 = shift_round(u * u, 12);
      u3 = shift_round(u * u * u, 26);
      g = 3 * a * u2;
      r[0*32 +: 32] = clamp32(shift_round(u * cv, 14));
      r[1*32 +: 32] = clamp32(shift_round(u * sv, 14));
      r[2*32 +: 32] = clamp32(shift_round(a * u3 * s3, 28));
      r[3*32 +: 32] = clamp32(cv);
      r[4*32 +: 32] = clamp32(sv);
      r[5*32 +: 32] = clamp32(shift_round(g * s3, 28));
      r[6*32 +: 32] = clamp32(-sg * sv);
      r[7*32 +: 32] = clamp32(sg * cv);
      r[8*32 +: 32] = clamp32(shift_round(g * sg * c3, 28));
      r[9*32 +: 32] = clamp32(-shift_round(g * sg * s2, 28));
      r[10*32 +: 32] = clamp32(-shift_round(g * sg * c2, 28));
      r[11*32 +: 32] = clamp32(sg * 65536);
      return r;
   endfunction

   function automatic void build_quarter_sine();
      for (int k = 0; k <= TAB_Q; k++) begin
         longint unsigned th, th2, term;
         longint sum, val;
         th = (PI_HALF_Q30 * k + (TAB_Q >> 1)) >> SINE_TABLE_ADDR_BITS;
         th2 = (th * th + (64'd1 << 29)) >> 30;
         term = th;
         sum = th;
         for (int n = 1; n <= 6; n++) begin
            term = ((term * th2) >> 30) / ((2 * n) * (2 * n + 1));
            sum = (n % 2) ? sum - longint'(term) : sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         val = (sum + 8192) >>> 14;
         if (val > 65536) val = 65536;
         quarter_sine[k] = val;
      end
   endfunction

   function automatic bit roll_src_idle();
      if (pace == MODE_SRC_GAPS) return $urandom_range(99) < 46;
      if (pace == MODE_BOTH) return $urandom_range(99) < 31;
      return 0;
   endfunction

   function automatic bit roll_sink_stall();
      if (pace == MODE_SINK_STALLS) return $urandom_range(99) < 46;
      if (pace == MODE_BOTH) return $urandom_range(99) < 31;
      return 0;
   endfunction

   // sink side: check each transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_surfaces.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %h", $time, rsp_tdata);
            failed = 1'b1;
         end else begin
            surface_type want;
            want = expected_surfaces.pop_front();
            for (int f = 0; f < 12; f++) begin
               if (want[f*32 +: 32] !== rsp_tdata[f*32 +: 32]) begin
                  $display("%0t field %0d mismatch: expected %h, actual %h",
                           $time, f, want[f*32 +: 32], rsp_tdata[f*32 +: 32]);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !roll_sink_stall();
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_sample(sample_type smp, logic has_fixed, surface_type fixed);
      while (roll_src_idle()) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {smp.angle, smp.radius};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_surfaces.push_back(has_fixed ? fixed : eval_surface(smp, gain_model));
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_surfaces.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 4) @(negedge clock);
   endtask

   task automatic write_gain(logic signed [15:0] g);
      drain();
      csr_wen <= 1'b1;
      csr_wdata <= g;
      gain_model = g;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   function automatic sample_type rand_sample();
      sample_type s;
      s.angle = 16'($urandom_range(16'hFFFF));
      case ($urandom_range(7))
         0: s.radius = 16'sh7FFF;
         1: s.radius = 16'sh8000;
         2: s.radius = 16'sd0;
         default: s.radius = 16'($urandom_range(16'hFFFF));
      endcase
      return s;
   endfunction

   initial begin
      table_row_type rows [$];
      logic signed [15:0] gains [6];
      surface_type zero_row;
      failed = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_wdata = '0;
      gain_model = GAIN_RESET;
      pace = MODE_FREE;
      build_quarter_sine();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero radius at angle zero: only du_x = 1.0 is nonzero
      zero_row = '0;
      zero_row[3*32 +: 32] = 32'h0001_0000;
      rows.push_back('{'{16'sd0, 16'h0000}, 1'b1, zero_row});
      rows.push_back('{'{16'sd0, 16'h4000}, 1'b0, '0});
      rows.push_back('{'{16'sh7FFF, 16'h0000}, 1'b0, '0});
      rows.push_back('{'{16'sh8000, 16'h0000}, 1'b0, '0});
      rows.push_back('{'{16'sh7FFF, 16'hFFFF}, 1'b0, '0});
      rows.push_back('{'{16'sh8000, 16'hFFFF}, 1'b0, '0});
      rows.push_back('{'{16'sd16384, 16'h4000}, 1'b0, '0});
      rows.push_back('{'{16'sd16384, 16'h8000}, 1'b0, '0});
      rows.push_back('{'{16'sd16384, 16'hC000}, 1'b0, '0});
      rows.push_back('{'{-16'sd16384, 16'h2AAA}, 1'b0, '0});
      rows.push_back('{'{16'sd1, 16'h5555}, 1'b0, '0});
      rows.push_back('{'{-16'sd1, 16'hAAAB}, 1'b0, '0});
      rows.push_back('{'{16'sh5A5A, 16'h3FFF}, 1'b0, '0});
      rows.push_back('{'{16'shA5A5, 16'h0010}, 1'b0, '0});
      foreach (rows[i]) send_sample(rows[i].smp, rows[i].has_fixed, rows[i].fixed);

      gains = '{16'sh7FFF, 16'sh8000, 16'sd0, -16'sd4096, 16'sh5A5A, GAIN_RESET};
      for (int ph = 0; ph < 6; ph++) begin
         write_gain(gains[ph]);
         send_sample('{16'sh7FFF, 16'h1555}, 1'b0, '0);
         send_sample('{16'sh8000, 16'h2AAA}, 1'b0, '0);
      end

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 125 == 0) begin
            pace = pace_type'((i / 125) % 4);
            if (i % 250 == 0) write_gain(16'($urandom_range(16'hFFFF)));
         end
         send_sample(rand_sample(), 1'b0, '0);
      end
      pace = MODE_FREE;
      drain();
      if (failed || expected_surfaces.size() != 0) begin
         $display("TB_ERROR");
      end else begin
         $display("TB_OK");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
hdl/msse_pkg.sv
hdl/msse_sin_lut.sv
hdl/monkey_saddle_surface_eval_unit.sv
bench/monkey_saddle_surface_eval_unit_test.sv
